[hdl/rlsd_pkg.sv]
// Package with the types, constants and register codes of the serial RGB LED bit driver.
package rlsd_pkg;

  localparam int unsigned COLOR_BITS = 24;
  localparam int unsigned BITS_W     = $clog2(COLOR_BITS + 1);
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [23:0]        LAST_COLOR_RST = 24'h123456;
  localparam logic [GAP_W-1:0]   GAP_MAX        = 16'hFFFF;
  localparam logic [TICK_W-1:0]  ONE_HIGH_RST   = 10'd96;
  localparam logic [TICK_W-1:0]  ONE_LOW_RST    = 10'd54;
  localparam logic [TICK_W-1:0]  ZERO_HIGH_RST  = 10'd48;
  localparam logic [TICK_W-1:0]  ZERO_LOW_RST   = 10'd102;
  localparam logic [GAP_W-1:0]   QUIET_GAP_RST  = 16'd36000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_HIGH  = 3'd0,
    CFG_ONE_LOW   = 3'd1,
    CFG_ZERO_HIGH = 3'd2,
    CFG_ZERO_LOW  = 3'd3,
    CFG_QUIET_GAP = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        action;
    logic [23:0] color;
  } in_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic accepted;
    logic skipped;
  } out_t;

  typedef struct packed {
    logic [TICK_W-1:0] one_high_ticks;
    logic [TICK_W-1:0] one_low_ticks;
    logic [TICK_W-1:0] zero_high_ticks;
    logic [TICK_W-1:0] zero_low_ticks;
    logic [GAP_W-1:0]  quiet_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [23:0]           last_sent_color;
    logic [COLOR_BITS-1:0] shift_bits;
    logic [BITS_W-1:0]     bits_left;
    logic [TICK_W-1:0]     phase_count;
    logic                  phase_is_high;
    logic                  sending;
    logic                  start_pending;
    logic [GAP_W-1:0]      gap_elapsed;
  } state_t;

  localparam state_t STATE_RST = '{
    last_sent_color: LAST_COLOR_RST,
    shift_bits:      '0,
    bits_left:       '0,
    phase_count:     '0,
    phase_is_high:   1'b0,
    sending:         1'b0,
    start_pending:   1'b0,
    gap_elapsed:     '0
  };

endpackage

[hdl/rlsd_cfg.sv]
// Configuration registers of the serial RGB LED bit driver.
module rlsd_cfg
  import rlsd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ONE_HIGH:  cfg_d.one_high_ticks  = cfg_wdata_i[TICK_W-1:0];
        CFG_ONE_LOW:   cfg_d.one_low_ticks   = cfg_wdata_i[TICK_W-1:0];
        CFG_ZERO_HIGH: cfg_d.zero_high_ticks = cfg_wdata_i[TICK_W-1:0];
        CFG_ZERO_LOW:  cfg_d.zero_low_ticks  = cfg_wdata_i[TICK_W-1:0];
        CFG_QUIET_GAP: cfg_d.quiet_gap_ticks = cfg_wdata_i[GAP_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high_ticks  <= ONE_HIGH_RST;
      cfg_q.one_low_ticks   <= ONE_LOW_RST;
      cfg_q.zero_high_ticks <= ZERO_HIGH_RST;
      cfg_q.zero_low_ticks  <= ZERO_LOW_RST;
      cfg_q.quiet_gap_ticks <= QUIET_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/rlsd_step.sv]
// Next-state and result logic for one tick of the serial RGB LED bit driver.
module rlsd_step
  import rlsd_pkg::*;
(
  input  state_t state_i,
  input  cfg_t   cfg_i,
  input  in_t    req_i,
  output state_t state_o,
  output out_t   res_o
);

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  state_t s;
  logic   acc;
  logic   skp;
  logic   busy;
  logic   pin;
  logic   top;
  logic [TICK_W-1:0] high_len;
  logic [TICK_W-1:0] low_len;
  logic [TICK_W-1:0] next_high_len;
  logic [COLOR_BITS-1:0] shifted;

  always_comb begin
    s   = state_i;
    acc = 1'b0;
    skp = 1'b0;

    if (req_i.action && !s.sending && !s.start_pending) begin
      acc = 1'b1;
      if (req_i.color == s.last_sent_color) begin
        skp = 1'b1;
      end else begin
        s.last_sent_color = req_i.color;
        s.shift_bits      = COLOR_BITS'(req_i.color);
        s.start_pending   = 1'b1;
      end
    end

    top      = s.shift_bits[COLOR_BITS-1];
    high_len = at_least_one(top ? cfg_i.one_high_ticks : cfg_i.zero_high_ticks);
    low_len  = at_least_one(top ? cfg_i.one_low_ticks : cfg_i.zero_low_ticks);
    shifted  = {s.shift_bits[COLOR_BITS-2:0], 1'b0};
    next_high_len = at_least_one(shifted[COLOR_BITS-1] ? cfg_i.one_high_ticks
                                                       : cfg_i.zero_high_ticks);

    if (!s.sending) begin
      if (s.start_pending && (s.gap_elapsed >= cfg_i.quiet_gap_ticks)) begin
        s.sending       = 1'b1;
        s.start_pending = 1'b0;
        s.bits_left     = BITS_W'(COLOR_BITS);
        s.phase_is_high = 1'b1;
        s.phase_count   = high_len;
      end else if (s.gap_elapsed < GAP_MAX) begin
        s.gap_elapsed = s.gap_elapsed + GAP_W'(1);
      end
    end

    busy = s.sending | s.start_pending;
    pin  = s.sending & s.phase_is_high;

    if (s.sending) begin
      if (s.phase_count != '0) begin
        s.phase_count = s.phase_count - TICK_W'(1);
      end
      if (s.phase_count == '0) begin
        if (s.phase_is_high) begin
          s.phase_is_high = 1'b0;
          s.phase_count   = low_len;
        end else begin
          s.shift_bits = shifted;
          if (s.bits_left != '0) begin
            s.bits_left = s.bits_left - BITS_W'(1);
          end
          if (s.bits_left == '0) begin
            s.sending     = 1'b0;
            s.gap_elapsed = '0;
          end else begin
            s.phase_is_high = 1'b1;
            s.phase_count   = next_high_len;
          end
        end
      end
    end

    state_o         = s;
    res_o.pin_level = pin;
    res_o.busy_res  = busy;
    res_o.accepted  = acc;
    res_o.skipped   = skp;
  end

endmodule

[hdl/rgb_led_serial_bit_driver.sv]
// Top level of the serial RGB LED bit driver with state and result registers.
// Latency: the result of a request is valid in the cycle after it is accepted.
// Throughput: one request per cycle with out_ready_i high (one-pass logic).
// A new request is taken while the result register empties in the same cycle.
// Reset clears the timing state, sets the last colour to its reset value,
// loads the default timing registers and empties the result register.
module rgb_led_serial_bit_driver
  import rlsd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_res_o
);

  cfg_t   cfg;
  state_t state_q;
  state_t state_d;
  out_t   res_d;
  out_t   res_q;
  logic   out_valid_q;
  logic   in_fire;

  rlsd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rlsd_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg),
    .req_i   (in_req_i),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef NO_ASSERTIONS
  a_taken_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.accepted && !res_q.skipped |-> res_q.busy_res)
    else $error("accepted new colour not shown as busy");

  a_pin_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.pin_level |-> res_q.busy_res)
    else $error("pin high outside a frame");

  a_sending_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.sending |-> (state_q.bits_left != '0))
    else $error("frame in progress with no bits left");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("empty result register refuses a request");
`endif

endmodule
